// File: rtl/core/ietacc_pkg.sv
// shared types and constants of the ion event tally accumulator
package ietacc_pkg;

    localparam int NUM_TALLIES = 17;
    localparam int DELTA_W     = 35;
    localparam int PAIR_W      = 20;
    localparam int NUM_REGS    = 8;

    localparam logic [2:0] MODE_CROSS   = 3'd0;
    localparam logic [2:0] MODE_REPLACE = 3'd1;
    localparam logic [2:0] MODE_STOP    = 3'd2;
    localparam logic [2:0] MODE_EXIT    = 3'd3;
    localparam logic [2:0] MODE_CASCADE = 3'd4;
    localparam logic [2:0] MODE_READ    = 3'd5;

    localparam logic [4:0] T_VAC      = 5'd0;
    localparam logic [4:0] T_IMP      = 5'd1;
    localparam logic [4:0] T_REPL     = 5'd2;
    localparam logic [4:0] T_DISP     = 5'd3;
    localparam logic [4:0] T_IONIZ    = 5'd4;
    localparam logic [4:0] T_LATT     = 5'd5;
    localparam logic [4:0] T_STORED   = 5'd6;
    localparam logic [4:0] T_ELOST    = 5'd7;
    localparam logic [4:0] T_PKA      = 5'd8;
    localparam logic [4:0] T_EPKA     = 5'd9;
    localparam logic [4:0] T_TDAM     = 5'd10;
    localparam logic [4:0] T_TDAM_LSS = 5'd11;
    localparam logic [4:0] T_VNRT     = 5'd12;
    localparam logic [4:0] T_VNRT_LSS = 5'd13;
    localparam logic [4:0] T_PATH     = 5'd14;
    localparam logic [4:0] T_COLL     = 5'd15;
    localparam logic [4:0] T_CLOST    = 5'd16;

    typedef struct packed {
        logic [2:0]  mode;
        logic [2:0]  species;
        logic [9:0]  cell_now;
        logic [9:0]  cell_before;
        logic [9:0]  cell_start;
        logic        is_recoil;
        logic [4:0]  aux_index;
        logic [31:0] value_a;
        logic [31:0] value_b;
        logic [31:0] value_c;
        logic [31:0] value_d;
        logic [31:0] value_e;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] tally_value;
        logic               saturated;
    } out_item_t;

    // one tally update of an event
    typedef struct packed {
        logic [4:0]                tally;
        logic [4:0]                species;
        logic [9:0]                cell_idx;
        logic signed [DELTA_W-1:0] delta;
        logic                      last;
    } upd_op_t;

endpackage

// File: rtl/core/ietacc_ram.sv
// tally memory, one write port and one registered read port
module ietacc_ram #(
    parameter int DEPTH  = 139264,
    parameter int WIDTH  = 48,
    parameter int ADDR_W = 18
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/ietacc_seq.sv
// event decoder: gives the tally update for each step of an event
module ietacc_seq (
    input  ietacc_pkg::in_item_t item,
    input  logic [18:0]          half,
    input  logic [3:0]           step,
    output ietacc_pkg::upd_op_t  op
);

    logic [3:0]                           j;
    logic [3:0]                           count;
    logic [3:0]                           pre;
    logic signed [ietacc_pkg::DELTA_W-1:0] da, db, dc, dd, de, dec, dh, one;
    logic [4:0]                           s5;

    always_comb
    begin
        da  = ietacc_pkg::DELTA_W'({1'b0, item.value_a});
        db  = ietacc_pkg::DELTA_W'({1'b0, item.value_b});
        dc  = ietacc_pkg::DELTA_W'({1'b0, item.value_c});
        dd  = ietacc_pkg::DELTA_W'({1'b0, item.value_d});
        de  = ietacc_pkg::DELTA_W'({1'b0, item.value_e});
        dec = de + dc;
        dh  = ietacc_pkg::DELTA_W'({1'b0, half});
        one = ietacc_pkg::DELTA_W'(1);
        s5  = {2'b00, item.species};

        pre   = (item.mode == ietacc_pkg::MODE_REPLACE) ? 4'd4 : 4'd1;
        count = 4'd1;
        unique case (item.mode)
            ietacc_pkg::MODE_CROSS:   count = 4'd4;
            ietacc_pkg::MODE_REPLACE: count = item.is_recoil ? 4'd12 : 4'd8;
            ietacc_pkg::MODE_STOP:    count = item.is_recoil ? 4'd9 : 4'd5;
            ietacc_pkg::MODE_EXIT:    count = item.is_recoil ? 4'd10 : 4'd6;
            ietacc_pkg::MODE_CASCADE: count = 4'd6;
            default:                  count = 4'd1;
        endcase

        // without a recoil the recoil group is skipped
        j = step;
        if (!item.is_recoil && step >= pre &&
            (item.mode == ietacc_pkg::MODE_REPLACE || item.mode == ietacc_pkg::MODE_STOP ||
             item.mode == ietacc_pkg::MODE_EXIT))
        begin
            j = step + 4'd4;
        end

        op.tally    = ietacc_pkg::T_COLL;
        op.species  = s5;
        op.cell_idx = item.cell_now;
        op.delta    = '0;
        op.last     = (step == count - 4'd1);

        // recoil group: three updates at the start cell, the last at the current cell
        if (item.mode != ietacc_pkg::MODE_CROSS && item.mode != ietacc_pkg::MODE_CASCADE &&
            item.mode != ietacc_pkg::MODE_READ && j >= pre && j < pre + 4'd4)
        begin
            unique case (j - pre)
                4'd0:
                begin
                    op.tally    = ietacc_pkg::T_DISP;
                    op.cell_idx = item.cell_start;
                    op.delta    = one;
                end
                4'd1:
                begin
                    op.tally    = ietacc_pkg::T_VAC;
                    op.cell_idx = item.cell_start;
                    op.delta    = one;
                end
                4'd2:
                begin
                    op.tally    = ietacc_pkg::T_STORED;
                    op.cell_idx = item.cell_start;
                    op.delta    = dh;
                end
                default:
                begin
                    op.tally = (item.mode == ietacc_pkg::MODE_STOP) ?
                               ietacc_pkg::T_STORED : ietacc_pkg::T_LATT;
                    op.delta = dh;
                end
            endcase
        end
        else
        begin
            unique case (item.mode)
                ietacc_pkg::MODE_CROSS:
                begin
                    op.cell_idx = item.cell_before;
                    unique case (j)
                        4'd0:
                        begin
                            op.tally = ietacc_pkg::T_COLL;
                            op.delta = da;
                        end
                        4'd1:
                        begin
                            op.tally = ietacc_pkg::T_PATH;
                            op.delta = db;
                        end
                        4'd2:
                        begin
                            op.tally = ietacc_pkg::T_LATT;
                            op.delta = dc;
                        end
                        default:
                        begin
                            op.tally = ietacc_pkg::T_IONIZ;
                            op.delta = dd;
                        end
                    endcase
                end
                ietacc_pkg::MODE_REPLACE, ietacc_pkg::MODE_STOP:
                begin
                    unique case (j)
                        4'd0:
                        begin
                            op.tally = (item.mode == ietacc_pkg::MODE_STOP) ?
                                       ietacc_pkg::T_IMP : ietacc_pkg::T_REPL;
                            op.delta = one;
                        end
                        4'd1:
                        begin
                            op.tally   = ietacc_pkg::T_VAC;
                            op.species = item.aux_index;
                            op.delta   = -one;
                        end
                        4'd2:
                        begin
                            op.tally   = ietacc_pkg::T_STORED;
                            op.species = item.aux_index;
                            op.delta   = -dh;
                        end
                        4'd3:
                        begin
                            op.tally   = ietacc_pkg::T_LATT;
                            op.species = item.aux_index;
                            op.delta   = dh;
                        end
                        default:
                        begin
                            unique case (j - pre - 4'd4)
                                4'd0:
                                begin
                                    op.tally = ietacc_pkg::T_COLL;
                                    op.delta = da;
                                end
                                4'd1:
                                begin
                                    op.tally = ietacc_pkg::T_PATH;
                                    op.delta = db;
                                end
                                4'd2:
                                begin
                                    op.tally = ietacc_pkg::T_IONIZ;
                                    op.delta = dd;
                                end
                                default:
                                begin
                                    op.tally = ietacc_pkg::T_LATT;
                                    op.delta = dec;
                                end
                            endcase
                        end
                    endcase
                end
                ietacc_pkg::MODE_EXIT:
                begin
                    op.cell_idx = item.cell_before;
                    if (j == 4'd0)
                    begin
                        op.tally = ietacc_pkg::T_CLOST;
                        op.delta = one;
                    end
                    else
                    begin
                        unique case (j - 4'd5)
                            4'd0:
                            begin
                                op.tally = ietacc_pkg::T_COLL;
                                op.delta = da;
                            end
                            4'd1:
                            begin
                                op.tally = ietacc_pkg::T_PATH;
                                op.delta = db;
                            end
                            4'd2:
                            begin
                                op.tally = ietacc_pkg::T_IONIZ;
                                op.delta = dd;
                            end
                            4'd3:
                            begin
                                op.tally = ietacc_pkg::T_LATT;
                                op.delta = dc;
                            end
                            default:
                            begin
                                op.tally = ietacc_pkg::T_ELOST;
                                op.delta = de;
                            end
                        endcase
                    end
                end
                ietacc_pkg::MODE_CASCADE:
                begin
                    unique case (j)
                        4'd0:
                        begin
                            op.tally = ietacc_pkg::T_PKA;
                            op.delta = one;
                        end
                        4'd1:
                        begin
                            op.tally = ietacc_pkg::T_EPKA;
                            op.delta = da;
                        end
                        4'd2:
                        begin
                            op.tally = ietacc_pkg::T_TDAM_LSS;
                            op.delta = db;
                        end
                        4'd3:
                        begin
                            op.tally = ietacc_pkg::T_VNRT_LSS;
                            op.delta = dc;
                        end
                        4'd4:
                        begin
                            op.tally = ietacc_pkg::T_TDAM;
                            op.delta = dd;
                        end
                        default:
                        begin
                            op.tally = ietacc_pkg::T_VNRT;
                            op.delta = de;
                        end
                    endcase
                end
                default:
                begin
                    op.tally = item.aux_index;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/ion_event_tally_accumulator.sv
// top level: event sequencing, saturating read-modify-write of the tally memory
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_data (event or read request)
//  out     | output    | out_valid/out_stall| out_data (tally read result)
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data (pair energies)
//
// each tally update is a memory read, then an add and write back, one update at a
// time; an update aimed at an out-of-range species or cell is skipped without a
// memory access; a read returns one tally, and an unused mode makes no update
// after reset a clearing pass writes 17 * NUM_SPECIES * NUM_CELLS zeros, one entry
// a cycle (139264 entries by default), with in_stall high; cfg writes are always taken
// a read result sits in the output register while the next item is accepted; a
// read that finds the output register still held stalls until it drains
module ion_event_tally_accumulator #(
    parameter int NUM_SPECIES = 8,
    parameter int NUM_CELLS   = 1024,
    parameter int ACC_WIDTH   = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  ietacc_pkg::in_item_t  in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output ietacc_pkg::out_item_t out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [19:0]           cfg_data
);

    localparam int PLANE  = NUM_SPECIES * NUM_CELLS;
    localparam int DEPTH  = ietacc_pkg::NUM_TALLIES * PLANE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SW     = ((ACC_WIDTH > ietacc_pkg::DELTA_W) ?
                             ACC_WIDTH : ietacc_pkg::DELTA_W) + 1;
    localparam logic signed [SW-1:0] ACC_MAX =
        {{(SW - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
    localparam logic signed [SW-1:0] ACC_MIN = ~ACC_MAX;
    localparam logic signed [64:0] OUT_MAX = 65'sh7FFF_FFFF_FFFF;
    localparam logic signed [64:0] OUT_MIN = ~OUT_MAX;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_MOD,
        ST_RDATA
    } state_t;

    state_t                                state_reg;
    ietacc_pkg::in_item_t                  item_reg;
    logic [3:0]                            step_reg;
    logic [ADDR_W-1:0]                     clr_reg;
    logic [ADDR_W-1:0]                     addr_reg;
    logic signed [ietacc_pkg::DELTA_W-1:0] delta_reg;
    logic                                  last_reg;
    logic                                  rd_ok_reg;
    logic                                  sat_reg;
    logic                                  out_valid_reg;
    ietacc_pkg::out_item_t                 out_data_reg;
    logic [ietacc_pkg::PAIR_W-1:0]         pair_reg [ietacc_pkg::NUM_REGS];

    ietacc_pkg::upd_op_t op;
    logic                loc_ok;
    logic [31:0]         lin;
    logic [ADDR_W-1:0]   addr;
    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ACC_WIDTH-1:0] ram_wdata, ram_rdata;
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] sum_sat;
    logic                 sat_hit;
    logic signed [64:0]   rd_ext;
    logic signed [47:0]   rd_clamp;

    ietacc_seq u_seq (
        .item (item_reg),
        .half (pair_reg[item_reg.species][ietacc_pkg::PAIR_W-1:1]),
        .step (step_reg),
        .op   (op)
    );

    ietacc_ram #(
        .DEPTH  (DEPTH),
        .WIDTH  (ACC_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        loc_ok = (32'(op.species) < 32'(NUM_SPECIES)) &&
                 (32'(op.cell_idx) < 32'(NUM_CELLS)) &&
                 (32'(op.tally) < 32'(ietacc_pkg::NUM_TALLIES));
        lin    = 32'(op.tally) * 32'(PLANE) + 32'(op.species) * 32'(NUM_CELLS) +
                 32'(op.cell_idx);
        addr   = lin[ADDR_W-1:0];
        ram_re = (state_reg == ST_ISSUE) && loc_ok && (item_reg.mode <= ietacc_pkg::MODE_READ);

        sum     = SW'($signed(ram_rdata)) + SW'(delta_reg);
        sat_hit = (sum > ACC_MAX) || (sum < ACC_MIN);
        priority if (sum > ACC_MAX)
            sum_sat = ACC_MAX;
        else if (sum < ACC_MIN)
            sum_sat = ACC_MIN;
        else
            sum_sat = sum;

        ram_we    = (state_reg == ST_CLEAR) || (state_reg == ST_MOD);
        ram_waddr = (state_reg == ST_CLEAR) ? clr_reg : addr_reg;
        ram_wdata = (state_reg == ST_CLEAR) ? '0 : sum_sat[ACC_WIDTH-1:0];

        rd_ext = 65'($signed(ram_rdata));
        priority if (!rd_ok_reg)
            rd_clamp = '0;
        else if (rd_ext > OUT_MAX)
            rd_clamp = OUT_MAX[47:0];
        else if (rd_ext < OUT_MIN)
            rd_clamp = OUT_MIN[47:0];
        else
            rd_clamp = rd_ext[47:0];
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ietacc_pkg::NUM_REGS; i++)
            begin
                pair_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            pair_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            item_reg <= in_data;
        end
        if (state_reg == ST_ISSUE)
        begin
            addr_reg  <= addr;
            delta_reg <= op.delta;
            last_reg  <= op.last;
            rd_ok_reg <= loc_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            step_reg      <= '0;
            clr_reg       <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (state_reg == ST_RDATA && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg            <= 1'b1;
                out_data_reg.tally_value <= rd_clamp;
                out_data_reg.saturated   <= sat_reg;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == ADDR_W'(DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE:
                begin
                    priority if (item_reg.mode == ietacc_pkg::MODE_READ)
                        state_reg <= ST_RDATA;
                    else if (item_reg.mode > ietacc_pkg::MODE_READ)
                        state_reg <= ST_IDLE;
                    else if (loc_ok)
                        state_reg <= ST_MOD;
                    else if (op.last)
                        state_reg <= ST_IDLE;
                    else
                        step_reg <= step_reg + 1'b1;
                end
                ST_MOD:
                begin
                    if (sat_hit)
                    begin
                        sat_reg <= 1'b1;
                    end
                    if (last_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        step_reg  <= step_reg + 1'b1;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_RDATA:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // an accepted transaction always starts issuing updates
    a_accept_issue: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_ISSUE)
        else $error("accepted transaction did not start");

    // the memory port never writes and reads in the same cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("memory read and write overlap");

    // a result appears only after a tally read
    a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RDATA))
        else $error("result without a tally read");

endmodule
